// ----- rtl/mtsd_pkg.sv -----
// Shared types, constants and key tables of the tile stream descrambler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtsd_pkg;

    localparam int LONG_TABLE_LEN  = 26;
    localparam int SHORT_TABLE_LEN = 13;
    localparam int POSITION_BITS   = 16;

    localparam int LIDX_W = 5;
    localparam int SIDX_W = 4;
    localparam int SEED_W = 10;
    localparam int KEY_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        MODE_TABLE_KEY   = 2'd0,
        MODE_FEEDBACK_A  = 2'd1,
        MODE_FEEDBACK_B  = 2'd2,
        MODE_SHORT_TABLE = 2'd3
    } mtsd_mode_t;

    typedef enum logic [1:0] {
        REG_MODE        = 2'd0,
        REG_INITIAL_KEY = 2'd1,
        REG_DEPTH_LIMIT = 2'd2,
        REG_UNUSED      = 2'd3
    } mtsd_reg_t;

    localparam logic [SEED_W-1:0] KEY_SEED_A = 10'h2E0;
    localparam logic [SEED_W-1:0] KEY_SEED_B = 10'h2B6;
    localparam logic [15:0]       MULT_A     = 16'h3222;
    localparam logic [15:0]       ADD_A      = 16'h83D2;
    localparam logic [15:0]       MULT_B     = 16'h336A;
    localparam logic [15:0]       ADD_B      = 16'h80C9;

    localparam logic [7:0] LONG_TAB [32] = '{
        8'h2D, 8'h4A, 8'h43, 8'hF1, 8'h27, 8'h9B, 8'h69, 8'h4F,
        8'h36, 8'h52, 8'h87, 8'hEC, 8'h5F, 8'h42, 8'h53, 8'h22,
        8'h9E, 8'h8B, 8'h2D, 8'h83, 8'h3D, 8'hD2, 8'h84, 8'hBA,
        8'hD8, 8'h5B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHORT_TAB [16] = '{
        8'h2D, 8'h4A, 8'h43, 8'hF1, 8'h27, 8'h9B, 8'h69, 8'h4F,
        8'h36, 8'h52, 8'h87, 8'hEC, 8'h5F, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        mtsd_mode_t  mode;
        logic [7:0]  initial_key;
        logic [15:0] depth_limit;
    } mtsd_cfg_t;

    // One classified beat: byte, restart flag and the key seed for a restart
    typedef struct packed {
        logic [7:0]        cipher;
        logic              first;
        logic [SEED_W-1:0] seed;
    } mtsd_item_t;

endpackage

`default_nettype wire

// ----- rtl/map_tile_stream_descrambler_core.sv -----
// Top level of the tile stream descrambler: register file, front stage,
// queue and back stage. Depends on mtsd_pkg, mtsd_front, mtsd_queue, mtsd_back.
`default_nettype none

// Takes one scrambled byte per beat and returns one descrambled byte per beat,
// in order. A beat with s_tuser set starts a new buffer. Throughput is one byte
// per clock while m_tready is held; a byte passes through the input register,
// the two-entry queue and the output register. The feedback key update is one 32x16
// multiply and add in the back stage, which sets the per-byte loop.
// Registers: mode at 0x0, initial_key at 0x4, depth_limit at 0x8; write them
// only while no bytes are in flight.
module map_tile_stream_descrambler_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mtsd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] cipher_byte
    input  wire logic                        s_tuser,   // [0] first
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata    // [7:0] plain_byte
);
    import mtsd_pkg::*;

    mtsd_cfg_t  cfg_reg, cfg_next;
    mtsd_reg_t  reg_sel;
    logic       cfg_write;

    logic       q_push, q_push_ready, q_valid, q_pop;
    mtsd_item_t front_item, q_item;

    assign pready    = 1'b1;
    assign reg_sel   = mtsd_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                REG_MODE:        cfg_next.mode        = mtsd_mode_t'(pwdata[1:0]);
                REG_INITIAL_KEY: cfg_next.initial_key = pwdata[7:0];
                REG_DEPTH_LIMIT: cfg_next.depth_limit = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MODE:        prdata = {30'd0, cfg_reg.mode};
            REG_INITIAL_KEY: prdata = {24'd0, cfg_reg.initial_key};
            REG_DEPTH_LIMIT: prdata = {16'd0, cfg_reg.depth_limit};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= MODE_TABLE_KEY;
            cfg_reg.initial_key <= '0;
            cfg_reg.depth_limit <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mtsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_item   (front_item),
        .q_ready  (q_push_ready)
    );

    mtsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (front_item),
        .push_ready (q_push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    mtsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/mtsd_front.sv -----
// Front stage: accepts input beats, registers them and works out the key seed.
// Depends on mtsd_pkg.
`default_nettype none

module mtsd_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mtsd_pkg::mtsd_cfg_t cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] cipher_byte
    input  wire logic                s_tuser,   // [0] first
    output logic                     q_push,
    output mtsd_pkg::mtsd_item_t     q_item,
    input  wire logic                q_ready
);
    import mtsd_pkg::*;

    logic       valid_reg, valid_next;
    mtsd_item_t item_reg, item_next;
    logic [SEED_W-1:0] seed;

    // Restart seed depends on the mode in force when the beat arrives
    always_comb begin
        seed = SEED_W'(cfg.initial_key)
             + ((cfg.mode == MODE_FEEDBACK_B) ? KEY_SEED_B : KEY_SEED_A);
    end

    assign s_tready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next.cipher = s_tdata;
                item_next.first  = s_tuser;
                item_next.seed   = seed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign q_push = valid_reg;
    assign q_item = item_reg;

endmodule

`default_nettype wire

// ----- rtl/mtsd_queue.sv -----
// Short queue of classified beats between the front and back stages.
// Depends on mtsd_pkg.
`default_nettype none

module mtsd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mtsd_pkg::mtsd_item_t push_item,
    output logic                      push_ready,
    output logic                      pop_valid,
    output mtsd_pkg::mtsd_item_t      pop_item,
    input  wire logic                 pop
);
    import mtsd_pkg::*;

    mtsd_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mtsd_back.sv -----
// Back stage: holds the buffer position, table indices and feedback key,
// descrambles one beat per cycle while the output is not stalled into the output register. Depends on mtsd_pkg.
`default_nettype none

module mtsd_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mtsd_pkg::mtsd_cfg_t  cfg,
    input  wire logic                 q_valid,
    input  wire mtsd_pkg::mtsd_item_t q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata    // [7:0] plain_byte
);
    import mtsd_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_eff;
    logic [KEY_W-1:0]         key_reg, key_next, key_eff;
    logic [LIDX_W-1:0]        lidx_reg, lidx_next, lidx_eff;
    logic [SIDX_W-1:0]        sidx_reg, sidx_next, sidx_eff;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_data_reg, out_data_next;

    logic              active;
    logic [KEY_W-1:0]  key_sum;
    logic [KEY_W-1:0]  key_fb_a, key_fb_b;
    logic [LIDX_W:0]   lidx_inc;
    logic [SIDX_W:0]   sidx_inc;
    logic [7:0]        long_key;
    logic [7:0]        plain;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // A restart beat uses position zero and a fresh seed
    always_comb begin
        pos_eff  = q_item.first ? '0 : pos_reg;
        lidx_eff = q_item.first ? '0 : lidx_reg;
        sidx_eff = q_item.first ? '0 : sidx_reg;
        key_eff  = q_item.first ? KEY_W'(q_item.seed) : key_reg;
    end

    always_comb begin
        active   = (32'(pos_eff) < 32'(cfg.depth_limit));
        key_sum  = KEY_W'(q_item.cipher) + key_eff;
        key_fb_a = KEY_W'(key_sum * KEY_W'(MULT_A)) + KEY_W'(ADD_A);
        key_fb_b = KEY_W'(key_sum * KEY_W'(MULT_B)) + KEY_W'(ADD_B);
        lidx_inc = {1'b0, lidx_eff} + 1'b1;
        sidx_inc = {1'b0, sidx_eff} + 1'b1;
        long_key = LONG_TAB[lidx_eff] + cfg.initial_key;
    end

    always_comb begin
        plain = q_item.cipher;
        if (active) begin
            unique case (cfg.mode)
                MODE_TABLE_KEY:   plain = q_item.cipher ^ long_key;
                MODE_FEEDBACK_A,
                MODE_FEEDBACK_B:  plain = q_item.cipher ^ key_eff[15:8];
                MODE_SHORT_TABLE: plain = q_item.cipher ^ SHORT_TAB[sidx_eff];
                default:          plain = q_item.cipher;
            endcase
        end
    end

    always_comb begin
        pos_next  = pos_reg;
        key_next  = key_reg;
        lidx_next = lidx_reg;
        sidx_next = sidx_reg;
        if (q_pop) begin
            pos_next  = pos_eff;
            key_next  = key_eff;
            lidx_next = lidx_eff;
            sidx_next = sidx_eff;
            if (active) begin
                unique case (cfg.mode)
                    MODE_FEEDBACK_A: key_next = key_fb_a;
                    MODE_FEEDBACK_B: key_next = key_fb_b;
                    default:         key_next = key_eff;
                endcase
                lidx_next = (lidx_inc >= (LIDX_W + 1)'(LONG_TABLE_LEN))
                          ? '0 : lidx_inc[LIDX_W-1:0];
                sidx_next = (sidx_inc >= (SIDX_W + 1)'(SHORT_TABLE_LEN))
                          ? '0 : sidx_inc[SIDX_W-1:0];
                // hold at the top of the range
                if (pos_eff != '1) begin
                    pos_next = pos_eff + 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_data_next  = plain;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            key_reg       <= '0;
            lidx_reg      <= '0;
            sidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            key_reg       <= key_next;
            lidx_reg      <= lidx_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- dv/tb_map_tile_stream_descrambler_core.sv -----
// Testbench for map_tile_stream_descrambler_core: directed and random byte streams
// checked beat by beat against an in-bench descrambler predictor.
// Depends on mtsd_pkg and the RTL of the block.
module tb_map_tile_stream_descrambler_core;
    import mtsd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;     // [7:0] cipher_byte
    logic                s_tuser  = 1'b0;   // [0] first
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;           // [7:0] plain_byte

    // Predictor state and its copy of the registers
    mtsd_mode_t               cfg_mode  = MODE_TABLE_KEY;
    logic [7:0]               cfg_ikey  = '0;
    logic [15:0]              cfg_depth = '0;
    logic [POSITION_BITS-1:0] buf_pos   = '0;
    logic [KEY_W-1:0]         fb_key    = '0;
    logic [LIDX_W-1:0]        long_idx  = '0;
    logic [SIDX_W-1:0]        short_idx = '0;

    logic [7:0] plain_q[$];
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         hold_cycles = 0;
    int         rx_pattern  = 0;
    int         burst_left  = 0;
    int         gap_max     = 4;

    map_tile_stream_descrambler_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] descramble_byte(input logic [7:0] cb, input logic restart);
        logic [7:0] pb;
        logic [7:0] kb;
        pb = cb;
        if (restart) begin
            buf_pos   = '0;
            long_idx  = '0;
            short_idx = '0;
            fb_key    = 32'(cfg_ikey)
                      + 32'((cfg_mode == MODE_FEEDBACK_B) ? KEY_SEED_B : KEY_SEED_A);
        end
        if (32'(buf_pos) < 32'(cfg_depth)) begin
            case (cfg_mode)
                MODE_TABLE_KEY: begin
                    kb = LONG_TAB[long_idx] + cfg_ikey;
                    pb = cb ^ kb;
                end
                MODE_FEEDBACK_A: begin
                    pb     = cb ^ fb_key[15:8];
                    fb_key = (32'(cb) + fb_key) * 32'(MULT_A) + 32'(ADD_A);
                end
                MODE_FEEDBACK_B: begin
                    pb     = cb ^ fb_key[15:8];
                    fb_key = (32'(cb) + fb_key) * 32'(MULT_B) + 32'(ADD_B);
                end
                default: begin
                    pb = cb ^ SHORT_TAB[short_idx];
                end
            endcase
            long_idx  = (int'(long_idx) + 1 >= LONG_TABLE_LEN) ? '0 : long_idx + 1'b1;
            short_idx = (int'(short_idx) + 1 >= SHORT_TABLE_LEN) ? '0 : short_idx + 1'b1;
            if (buf_pos != '1)
                buf_pos = buf_pos + 1'b1;
        end
        return pb;
    endfunction

    // Mirror register writes into the predictor
    always @(posedge aclk) begin
        if (aresetn && psel && penable && pwrite && pready) begin
            case (mtsd_reg_t'(paddr[3:2]))
                REG_MODE:        cfg_mode  = mtsd_mode_t'(pwdata[1:0]);
                REG_INITIAL_KEY: cfg_ikey  = pwdata[7:0];
                REG_DEPTH_LIMIT: cfg_depth = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            plain_q.push_back(descramble_byte(s_tdata, s_tuser));
    end

    task automatic flag_error(input string what, input logic [7:0] exp_b,
                              input logic [7:0] act_b);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR %s: expected 0x%02h, got 0x%02h (cycle %0d)",
                     what, exp_b, act_b, cycle_count);
    endtask

    always @(posedge aclk) begin
        logic [7:0] exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_q.size() == 0) begin
                flag_error("unexpected plain byte", 8'h00, m_tdata);
            end else begin
                exp_b = plain_q.pop_front();
                if (m_tdata !== exp_b)
                    flag_error("plain_byte", exp_b, m_tdata);
            end
        end
    end

    // Receiver: long hold-off on request, else a stall pattern that changes now and then
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            if (cycle_count % 97 == 0)
                rx_pattern = $urandom_range(0, 3);
            case (rx_pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= (cycle_count % 3 != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_map_tile_stream_descrambler_core: FAIL");
            $finish;
        end
    end

    // Called at a rising edge; returns idle so psel is never driven twice in a step
    task automatic cfg_write(input mtsd_reg_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input mtsd_mode_t m, input logic [7:0] ik, input logic [15:0] dl);
        cfg_write(REG_MODE, 32'(m));
        cfg_write(REG_INITIAL_KEY, 32'(ik));
        cfg_write(REG_DEPTH_LIMIT, 32'(dl));
    endtask

    task automatic send_byte(input logic [7:0] cb, input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0) begin
                gap = $urandom_range(0, gap_max);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= cb;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every expected byte has come back
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (plain_q.size() != 0);
    endtask

    task automatic test_pass_through_after_reset();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    // Without a buffer start, key and position run on from their reset values
    task automatic test_no_first();
        set_config(MODE_FEEDBACK_A, 8'h5A, 16'd6);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_idle();
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 4; m++) begin
            set_config(mtsd_mode_t'(m), (m % 2 == 0) ? 8'hFF : 8'h00, 16'hFFFF);
            send_byte(8'h00, 1'b1);
            send_byte(8'hFF, 1'b0);
            send_byte(8'($urandom), 1'b0);
            wait_idle();
        end
    endtask

    // Bytes past the limit pass unchanged; a restart mid-stream re-opens the window
    task automatic test_depth_limit();
        set_config(MODE_SHORT_TABLE, 8'h33, 16'd2);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_idle();
    endtask

    task automatic test_mode_switch_in_buffer();
        set_config(MODE_FEEDBACK_B, 8'h80, 16'd10);
        send_byte(8'h12, 1'b1);
        wait_idle();
        cfg_write(REG_MODE, 32'(MODE_TABLE_KEY));
        send_byte(8'h34, 1'b0);
        wait_idle();
        cfg_write(REG_MODE, 32'(MODE_FEEDBACK_A));
        send_byte(8'h56, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(MODE_FEEDBACK_A, 8'($urandom), 16'd1000);
        gap_max     = 0;
        hold_cycles = 300;
        for (int i = 0; i < 60; i++)
            send_byte(8'($urandom), i == 0);
        wait_idle();
    endtask

    task automatic test_random_buffers();
        mtsd_mode_t m;
        logic [7:0] ik;
        logic [15:0] dl;
        int         sent;
        int         len;
        logic       restart;
        for (int ph = 0; ph < 12; ph++) begin
            m  = mtsd_mode_t'($urandom_range(0, 3));
            ik = 8'($urandom);
            dl = 16'($urandom_range(0, 48));
            case (ph % 4)
                0: begin ik = 8'hFF; dl = 16'hFFFF; end
                1: begin ik = 8'h00; dl = 16'd0; end
                2: dl = 16'($urandom);
                default: ;
            endcase
            set_config(m, ik, dl);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 8;
            endcase
            sent = 0;
            while (sent < 50) begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    // mostly well-formed buffers; some lack a start or restart mid-way
                    if (i == 0)
                        restart = ($urandom_range(0, 7) != 0);
                    else
                        restart = ($urandom_range(0, 15) == 0);
                    send_byte(8'($urandom), restart);
                end
                sent += len;
            end
            wait_idle();
        end
    endtask

    // One long buffer with the window fully open, sent back to back
    task automatic test_full_depth();
        set_config(MODE_FEEDBACK_B, 8'($urandom), 16'hFFFF);
        gap_max = 0;
        for (int i = 0; i < 60; i++)
            send_byte(8'($urandom), i == 0);
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pass_through_after_reset();
        test_no_first();
        test_each_mode();
        test_depth_limit();
        test_mode_switch_in_buffer();
        test_backpressure();
        test_random_buffers();
        test_full_depth();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && plain_q.size() == 0)
            $display("tb_map_tile_stream_descrambler_core: PASS");
        else
            $display("tb_map_tile_stream_descrambler_core: FAIL");
        $finish;
    end

endmodule
